>>> sv/hte_pkg.sv
// ----------------------------------------------------------------------------
// Huffman table encoder package
// Shared widths, command codes, defaults and the packer job record.
// ----------------------------------------------------------------------------
package hte_pkg;

	localparam int SYM_W     = 8;
	localparam int CODE_W    = 32;
	localparam int LEN_W     = 6;
	localparam int BYTE_W    = 8;
	localparam int PAD_W     = 4;
	localparam int PEND_W    = 7;
	localparam int CNT_W     = 3;
	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;

	// widest accumulator: longest code plus leftover bits
	localparam int ACC_MAX_W = CODE_W + PEND_W;
	localparam int REM_W     = $clog2(ACC_MAX_W + 1);

	localparam int DEF_MAX_CODE_LEN = 32;
	localparam int DEF_ALPHABET     = 256;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_LOAD   = 2'd0;
	localparam cmd_t CMD_ENCODE = 2'd1;
	localparam cmd_t CMD_FLUSH  = 2'd2;

	// one run of bytes handed to the packer
	typedef struct packed {
		logic [ACC_MAX_W-1:0] acc;  // bits right-aligned, earliest highest
		logic [REM_W-1:0]     rem;  // valid bits still to emit
		logic [PAD_W-1:0]     pad;  // pad count, flush only
	} job_t;

endpackage

>>> sv/hte_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module hte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/hte_packer.sv
// ----------------------------------------------------------------------------
// Huffman encoder byte packer
// Holds one job and drains it a byte per cycle into the output register while that register is free.
// ----------------------------------------------------------------------------
module hte_packer import hte_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  job_t                 job_in,
	input  logic                 job_load,
	output logic                 job_free,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    out_byte,
	output logic [PAD_W-1:0]     out_pad,
	output logic                 out_last
);

	job_t               job_q;
	logic               job_valid_q;
	logic               out_free;
	logic               job_last;
	logic [BYTE_W-1:0]  job_byte;
	logic [REM_W-1:0]   shift;

	assign out_free = !out_valid || out_ready;
	assign shift    = job_q.rem - REM_W'(BYTE_W);
	assign job_byte = BYTE_W'(job_q.acc >> shift);
	assign job_last = job_q.rem < REM_W'(2 * BYTE_W);
	assign job_free = !job_valid_q || (out_free && job_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid <= job_valid_q;
				if (job_valid_q) begin
					out_byte <= job_byte;
					out_pad  <= job_q.pad;
					out_last <= job_last;
				end
			end
			// a new job replaces one that is idle or sending its last byte
			if (job_load) begin
				job_valid_q <= 1'b1;
				job_q       <= job_in;
			end else if (out_free && job_valid_q) begin
				job_q.rem <= shift;
				if (job_last) begin
					job_valid_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> sv/huffman_table_encoder_packer_top.sv
// ----------------------------------------------------------------------------
// Huffman table encoder and bit packer, top level
// Loads a code table, encodes bytes into a packed bit stream, pads on flush.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one command per transfer (s_axis_tuser): load a
//   code entry, encode a byte, or flush. A load writes the code memory and
//   produces nothing. An encode produces zero to four bytes, a flush exactly
//   one byte with its pad count; m_axis_tlast marks the last byte of each
//   command.
//   The first byte of a command passes the code memory read register, the
//   packer's job register and then the output register.
//   Throughput: one input transfer per cycle while no bytes are produced;
//   otherwise the packer drains one byte per cycle while the receiver is
//   ready, up to four per encode. The single-job packer sets this rate.
//   Reset clears the pending bit buffer and one valid flag per table entry
//   at once, so every symbol reads absent; no clearing pass is needed and
//   inputs are taken from the first cycle after reset.
//   When the receiver stalls, the output register holds its byte, the packer
//   holds its job, and stage 1 and then s_axis_tready back up behind them.
// ----------------------------------------------------------------------------
module huffman_table_encoder_packer_top import hte_pkg::*; #(
	parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
	parameter int ALPHABET     = DEF_ALPHABET
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// [1:0] command
	input  logic [1:0]           s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// [7:0] out_byte, [11:8] pad_bits, [15:12] zero
	output logic [M_TDATA_W-1:0] m_axis_tdata,
	output logic                 m_axis_tlast
);

	// usable code length and derived widths
	localparam int LIM   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
	localparam int LW    = $clog2(LIM + 1);
	localparam int ENT_W = LIM + LW;
	localparam int ACC_W = LIM + PEND_W;
	localparam int TW    = $clog2(ACC_W + 1);
	localparam int AW    = $clog2(ALPHABET);

	// input unpacking
	logic [SYM_W-1:0]  in_sym;
	logic [CODE_W-1:0] in_code;
	logic [LEN_W-1:0]  in_len;
	cmd_t              in_cmd;
	logic              in_accept;
	logic              in_range;
	logic [AW-1:0]     in_addr;

	assign in_sym    = s_axis_tdata[SYM_W-1:0];
	assign in_code   = s_axis_tdata[SYM_W +: CODE_W];
	assign in_len    = s_axis_tdata[SYM_W + CODE_W +: LEN_W];
	assign in_cmd    = s_axis_tuser;
	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign in_range  = int'(in_sym) < ALPHABET;
	assign in_addr   = in_sym[AW-1:0];

	// load path: clamp the length, drop code bits above it
	logic [LW-1:0]    ld_len;
	logic [LIM-1:0]   ld_code;
	logic             ld_we;
	logic [ENT_W-1:0] ld_entry;

	assign ld_len   = (int'(in_len) > LIM) ? LW'(LIM) : in_len[LW-1:0];
	assign ld_code  = in_code[LIM-1:0] & ~({LIM{1'b1}} << ld_len);
	assign ld_entry = {ld_len, ld_code};
	assign ld_we    = in_accept && (in_cmd == CMD_LOAD) && in_range;

	// per-entry written flags; an unwritten entry reads as absent
	logic [ALPHABET-1:0] written_q;
	logic [ENT_W-1:0]    rd_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (ld_we) begin
			written_q[in_addr] <= 1'b1;
		end
	end

	hte_ram #(
		.WIDTH (ENT_W),
		.DEPTH (ALPHABET)
	) u_code_ram (
		.clk   (clk),
		.we    (ld_we),
		.waddr (in_addr),
		.wdata (ld_entry),
		.re    (in_accept),
		.raddr (in_addr),
		.rdata (rd_entry)
	);

	// stage 1: memory data arrives, merge with the pending bits
	logic valid_s1;
	cmd_t cmd_s1;
	logic hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
			cmd_s1   <= in_cmd;
			hit_s1   <= in_range && written_q[in_addr];
		end
	end

	logic [PEND_W-1:0] pend_bits_q;
	logic [CNT_W-1:0]  pend_cnt_q;
	logic [LW-1:0]     len_s1;
	logic [ACC_W-1:0]  acc_s1;
	logic [TW-1:0]     total_s1;
	logic              enc_live;
	logic              enc_job;
	logic              flush_s1;
	logic              need_job;
	logic              adv_s1;
	logic [PEND_W-1:0] next_bits;
	logic [PAD_W-1:0]  flush_pad;
	job_t              job;
	logic              job_load;
	logic              job_free;

	assign len_s1   = hit_s1 ? rd_entry[ENT_W-1:LIM] : '0;
	assign acc_s1   = (ACC_W'(pend_bits_q) << len_s1) | ACC_W'(rd_entry[LIM-1:0]);
	assign total_s1 = TW'(pend_cnt_q) + TW'(len_s1);
	assign enc_live = valid_s1 && (cmd_s1 == CMD_ENCODE) && (len_s1 != '0);
	assign enc_job  = enc_live && (total_s1 >= TW'(BYTE_W));
	assign flush_s1 = valid_s1 && (cmd_s1 == CMD_FLUSH);
	assign need_job = enc_job || flush_s1;
	assign adv_s1   = !need_job || job_free;
	assign job_load = need_job && job_free;

	// leftover bits after whole bytes are taken
	assign next_bits = acc_s1[PEND_W-1:0] & ~({PEND_W{1'b1}} << total_s1[CNT_W-1:0]);
	assign flush_pad = PAD_W'(BYTE_W) - PAD_W'(pend_cnt_q);

	always_comb begin
		if (flush_s1) begin
			job.acc = ACC_MAX_W'(BYTE_W'({1'b0, pend_bits_q} << flush_pad));
			job.rem = REM_W'(BYTE_W);
			job.pad = flush_pad;
		end else begin
			job.acc = ACC_MAX_W'(acc_s1);
			job.rem = REM_W'(total_s1);
			job.pad = '0;
		end
	end

	assign s_axis_tready = !valid_s1 || adv_s1;

	// advance the pending buffer as each item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= '0;
			pend_cnt_q  <= '0;
		end else if (adv_s1) begin
			if (flush_s1) begin
				pend_bits_q <= '0;
				pend_cnt_q  <= '0;
			end else if (enc_live) begin
				pend_bits_q <= next_bits;
				pend_cnt_q  <= total_s1[CNT_W-1:0];
			end
		end
	end

	// packer and output register
	logic [BYTE_W-1:0] out_byte;
	logic [PAD_W-1:0]  out_pad;

	hte_packer u_packer (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_in    (job),
		.job_load  (job_load),
		.job_free  (job_free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (out_byte),
		.out_pad   (out_pad),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {(M_TDATA_W - BYTE_W - PAD_W)'(0), out_pad, out_byte};

`ifndef NO_ASSERTIONS
	// a stalled stage 1 keeps its item
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(cmd_s1) && $stable(hit_s1))
		else $error("stage 1 item lost while stalled");

	// a flush leaves an empty buffer
	a_flush_clear: assert property (@(posedge clk) disable iff (!arst_n)
		flush_s1 && adv_s1 |=> pend_cnt_q == '0 && pend_bits_q == '0)
		else $error("pending bits survive a flush");

	// a padded byte always ends its command
	a_pad_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_pad != '0) |-> m_axis_tlast)
		else $error("padded byte without last");

	// leftover bits above the count stay zero
	a_pend_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_bits_q & ({PEND_W{1'b1}} << pend_cnt_q)) == '0)
		else $error("stray bits in pending buffer");
`endif

endmodule
